// ===== sv/received_sequence_interval_tracker_macros.svh =====
// Assertion macros for the received sequence interval tracker
`ifndef RECEIVED_SEQUENCE_INTERVAL_TRACKER_MACROS_SVH
`define RECEIVED_SEQUENCE_INTERVAL_TRACKER_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define RSIT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsit: same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define RSIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsit: next-cycle check failed");

`endif

// ===== sv/rsit_pkg.sv =====
// Package: shared types and constants of the received sequence interval tracker
`timescale 1ns / 1ps
package rsit_pkg;

  localparam int MAX_INTERVALS_DEF = 16;
  localparam int SEQ_W             = 31;
  localparam int BOUND_W           = 32;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t OP_HOLD       = 3'd0;
  localparam cell_op_t OP_LOAD       = 3'd1;
  localparam cell_op_t OP_FROM_LEFT  = 3'd2;
  localparam cell_op_t OP_FROM_RIGHT = 3'd3;
  localparam cell_op_t OP_SET_START  = 3'd4;
  localparam cell_op_t OP_SET_END    = 3'd5;
  localparam cell_op_t OP_MERGE      = 3'd6;

  typedef struct packed {
    logic end_below;   // end < number
    logic end_equal;   // end == number
    logic start_above; // start > number
    logic start_adj;   // start == number + 1
  } cell_flags_t;

endpackage

// ===== sv/rsit_cell.sv =====
// One interval cell: holds [start, end), compares against the number, shifts with neighbours
`timescale 1ns / 1ps
module rsit_cell
  import rsit_pkg::*;
(
  input  logic               clk,
  input  logic               flag_en,
  input  logic [SEQ_W-1:0]   seq,
  input  cell_op_t           op,
  input  logic [BOUND_W-1:0] left_start,
  input  logic [BOUND_W-1:0] left_end,
  input  logic [BOUND_W-1:0] right_start,
  input  logic [BOUND_W-1:0] right_end,
  output logic [BOUND_W-1:0] start_q,
  output logic [BOUND_W-1:0] end_q,
  output cell_flags_t        flags
);

  logic [BOUND_W-1:0] start_r, start_nxt;
  logic [BOUND_W-1:0] end_r, end_nxt;
  logic [BOUND_W-1:0] seq_ext, seq_inc;
  cell_flags_t        flags_r, flags_nxt;

  assign seq_ext = {1'b0, seq};
  assign seq_inc = seq_ext + BOUND_W'(1);

  always_comb begin
    flags_nxt.end_below   = end_r < seq_ext;
    flags_nxt.end_equal   = end_r == seq_ext;
    flags_nxt.start_above = start_r > seq_ext;
    flags_nxt.start_adj   = start_r == seq_inc;
  end

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    case (op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        start_nxt = seq_ext;
        end_nxt   = seq_inc;
      end
      OP_FROM_LEFT: begin
        start_nxt = left_start;
        end_nxt   = left_end;
      end
      OP_FROM_RIGHT: begin
        start_nxt = right_start;
        end_nxt   = right_end;
      end
      OP_SET_START: start_nxt = seq_ext;
      OP_SET_END:   end_nxt   = seq_inc;
      OP_MERGE:     end_nxt   = right_end;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
    if (flag_en) begin
      flags_r <= flags_nxt;
    end
  end

  assign start_q = start_r;
  assign end_q   = end_r;
  assign flags   = flags_r;

endmodule

// ===== sv/rsit_ctrl.sv =====
// Update decision: finds the target cell from the flags and issues one op per cell
`timescale 1ns / 1ps
module rsit_ctrl
  import rsit_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int CNT_W         = $clog2(MAX_INTERVALS + 1)
)(
  input  cell_flags_t [MAX_INTERVALS-1:0] flags,
  input  logic [CNT_W-1:0]                count,
  output cell_op_t    [MAX_INTERVALS-1:0] ops,
  output logic [CNT_W-1:0]                count_nxt,
  output logic                            res_dup,
  output logic                            res_ovf
);

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_INSERT    = 3'd1;
  localparam logic [2:0] ACT_SET_START = 3'd2;
  localparam logic [2:0] ACT_SET_END   = 3'd3;
  localparam logic [2:0] ACT_MERGE     = 3'd4;

  logic [MAX_INTERVALS-1:0] vld, lt, first, eqv, abv, adjv, nadj;
  logic                     full, f_vld, f_eq, f_above, f_adj, n_adj;
  logic [2:0]               act;

  assign full = count == CNT_W'(MAX_INTERVALS);

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_sel
    assign vld[k]  = CNT_W'(k) < count;
    assign lt[k]   = vld[k] & flags[k].end_below;
    assign eqv[k]  = flags[k].end_equal;
    assign abv[k]  = flags[k].start_above;
    assign adjv[k] = flags[k].start_adj;
    if (k == 0) begin : g_head
      assign first[k] = !lt[k];
    end else begin : g_body
      assign first[k] = !lt[k] && lt[k-1];
    end
    if (k == MAX_INTERVALS - 1) begin : g_last
      assign nadj[k] = 1'b0;
    end else begin : g_mid
      assign nadj[k] = first[k] & vld[k+1] & adjv[k+1];
    end
  end

  assign f_vld   = |(first & vld);
  assign f_eq    = |(first & eqv);
  assign f_above = |(first & abv);
  assign f_adj   = |(first & adjv);
  assign n_adj   = |nadj;

  always_comb begin
    act     = ACT_NONE;
    res_dup = 1'b0;
    res_ovf = 1'b0;
    if (!f_vld) begin
      if (full) res_ovf = 1'b1;
      else      act     = ACT_INSERT;
    end else if (!f_eq) begin
      if (f_above) begin
        if (f_adj)     act     = ACT_SET_START;
        else if (full) res_ovf = 1'b1;
        else           act     = ACT_INSERT;
      end else begin
        res_dup = 1'b1;
      end
    end else begin
      if (n_adj) act = ACT_MERGE;
      else       act = ACT_SET_END;
    end
  end

  always_comb begin
    case (act)
      ACT_INSERT: count_nxt = count + CNT_W'(1);
      ACT_MERGE:  count_nxt = count - CNT_W'(1);
      default:    count_nxt = count;
    endcase
  end

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_op
    logic tail;
    if (k == 0) begin : g_t0
      assign tail = 1'b0;
    end else begin : g_tk
      assign tail = !lt[k-1];
    end
    always_comb begin
      ops[k] = OP_HOLD;
      if (first[k]) begin
        case (act)
          ACT_INSERT:    ops[k] = OP_LOAD;
          ACT_SET_START: ops[k] = OP_SET_START;
          ACT_SET_END:   ops[k] = OP_SET_END;
          ACT_MERGE:     ops[k] = OP_MERGE;
          default:       ops[k] = OP_HOLD;
        endcase
      end else if (tail) begin
        case (act)
          ACT_INSERT: ops[k] = OP_FROM_LEFT;
          ACT_MERGE:  ops[k] = OP_FROM_RIGHT;
          default:    ops[k] = OP_HOLD;
        endcase
      end
    end
  end

endmodule

// ===== sv/received_sequence_interval_tracker.sv =====
// Top level: received sequence interval tracker, a chain of interval cells
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------
//   in      | input     | in_valid, in_ready, in_seq_number
//   out     | output    | out_valid, out_ready, out_is_duplicate,
//           |           | out_table_overflow
//
// Each item passes a compare step, which registers every cell's compares, and then
// an apply step, which applies the shift, merge or edge update across the chain and
// registers the result. A new item is taken in the apply step.
// Synchronous active-low reset empties the table (count to zero).
// A pending result that is not taken holds the apply cycle and the input.
`timescale 1ns / 1ps
`include "received_sequence_interval_tracker_macros.svh"
module received_sequence_interval_tracker
  import rsit_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SEQ_W-1:0] in_seq_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_duplicate,
  output logic             out_table_overflow
);

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, dup_r, ovf_r;
  logic             in_fire, apply_fire, res_dup, res_ovf;

  cell_flags_t [MAX_INTERVALS-1:0] flags;
  cell_op_t    [MAX_INTERVALS-1:0] ops;
  logic [BOUND_W-1:0]              start_q [MAX_INTERVALS];
  logic [BOUND_W-1:0]              end_q   [MAX_INTERVALS];

  assign apply_fire = (state_r == ST_APPLY) && (!out_valid_r || out_ready);
  assign in_ready   = (state_r == ST_IDLE) || apply_fire;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    case (state_r)
      ST_IDLE:  state_nxt = in_fire ? ST_CMP : ST_IDLE;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = in_fire ? ST_CMP : (apply_fire ? ST_IDLE : ST_APPLY);
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      seq_r <= in_seq_number;
    end
    if (apply_fire) begin
      dup_r <= res_dup;
      ovf_r <= res_ovf;
    end
  end

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    logic [BOUND_W-1:0] l_start, l_end, r_start, r_end;
    if (k == 0) begin : g_l0
      assign l_start = start_q[k];
      assign l_end   = end_q[k];
    end else begin : g_lk
      assign l_start = start_q[k-1];
      assign l_end   = end_q[k-1];
    end
    if (k == MAX_INTERVALS - 1) begin : g_rn
      assign r_start = start_q[k];
      assign r_end   = end_q[k];
    end else begin : g_rk
      assign r_start = start_q[k+1];
      assign r_end   = end_q[k+1];
    end
    rsit_cell u_cell (
      .clk         (clk),
      .flag_en     (state_r == ST_CMP),
      .seq         (seq_r),
      .op          (apply_fire ? ops[k] : OP_HOLD),
      .left_start  (l_start),
      .left_end    (l_end),
      .right_start (r_start),
      .right_end   (r_end),
      .start_q     (start_q[k]),
      .end_q       (end_q[k]),
      .flags       (flags[k])
    );
  end

  rsit_ctrl #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .flags     (flags),
    .count     (count_r),
    .ops       (ops),
    .count_nxt (count_nxt),
    .res_dup   (res_dup),
    .res_ovf   (res_ovf)
  );

  assign out_valid          = out_valid_r;
  assign out_is_duplicate   = dup_r;
  assign out_table_overflow = ovf_r;

  `RSIT_ASSERT_SAME(a_ovf_only_full, apply_fire && res_ovf, count_r == CNT_W'(MAX_INTERVALS))
  `RSIT_ASSERT_SAME(a_dup_ovf_excl, apply_fire, !(res_dup && res_ovf))
  `RSIT_ASSERT_NEXT(a_dup_keeps_count, apply_fire && res_dup, count_r == $past(count_r))
  `RSIT_ASSERT_NEXT(a_take_then_cmp, in_fire, state_r == ST_CMP)
  `RSIT_ASSERT_NEXT(a_apply_gives_out, apply_fire, out_valid_r)

endmodule
